FILE: hdl/mat4a_pkg.sv
package mat4a_pkg;

    localparam int ELEM_W = 32;
    localparam int LANES  = 4;
    localparam int ROWS   = 4;

    localparam logic [3:0] OP_LOADA = 4'd0;
    localparam logic [3:0] OP_LOADB = 4'd1;
    localparam logic [3:0] OP_ADDS  = 4'd2;
    localparam logic [3:0] OP_SUBS  = 4'd3;
    localparam logic [3:0] OP_MULS  = 4'd4;
    localparam logic [3:0] OP_ADDB  = 4'd5;
    localparam logic [3:0] OP_SUBB  = 4'd6;
    localparam logic [3:0] OP_MULB  = 4'd7;
    localparam logic [3:0] OP_READ  = 4'd8;

    localparam logic [1:0] LANE_ADD = 2'd0;
    localparam logic [1:0] LANE_SUB = 2'd1;
    localparam logic [1:0] LANE_MUL = 2'd2;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [LANES-1:0] row_t;
    typedef row_t [ROWS-1:0] mat_t;

    typedef struct packed {
        logic [3:0] opcode;
        logic [1:0] row_index;
        elem_t      lane0_value;
        elem_t      lane1_value;
        elem_t      lane2_value;
        elem_t      lane3_value;
    } cmd_t;

    typedef struct packed {
        elem_t row_out0;
        elem_t row_out1;
        elem_t row_out2;
        elem_t row_out3;
        logic  saturated;
    } rsp_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
        logic       first;
        logic       last;
    } lane_ctl_t;

    typedef struct packed {
        logic       load_a;
        logic       load_b;
        logic       rot_a;
        logic       rot_b;
        logic       wr_a;
        logic [1:0] row;
    } store_ctl_t;

endpackage

FILE: hdl/mat4a_lane.sv
module mat4a_lane
    import mat4a_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  lane_ctl_t ctl,
    input  elem_t     a,
    input  elem_t     b,
    output logic      res_valid,
    output elem_t     res,
    output logic      clip
);

    localparam int ACC_W = 66 - FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod;
    logic signed [63:0] val_next;
    logic signed [63:0] rnd;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] sum;
    logic ovf;

    logic s1_valid_reg;
    logic s1_mul_reg;
    logic s1_first_reg;
    logic s1_last_reg;
    logic signed [63:0] s1_val_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic res_valid_reg;
    elem_t res_reg;
    logic clip_reg;

    assign prod = a * b;

    always_comb
    begin
        case (ctl.mode)
            LANE_MUL: val_next = prod;
            LANE_SUB: val_next = 64'(a) - 64'(b);
            default:  val_next = 64'(a) + 64'(b);
        endcase
    end

    // round half up, then accumulate
    assign rnd  = (s1_val_reg + HALF) >>> FRAC_BITS;
    assign term = s1_mul_reg ? ACC_W'(rnd) : ACC_W'(s1_val_reg);
    assign sum  = (s1_first_reg ? '0 : acc_reg) + term;
    assign ovf  = (|sum[ACC_W-1:ELEM_W-1]) & ~(&sum[ACC_W-1:ELEM_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= ctl.valid;
            res_valid_reg <= s1_valid_reg & s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            s1_mul_reg   <= (ctl.mode == LANE_MUL);
            s1_first_reg <= ctl.first;
            s1_last_reg  <= ctl.last;
            s1_val_reg   <= val_next;
        end
        if (s1_valid_reg)
        begin
            acc_reg <= sum;
            if (s1_last_reg)
            begin
                clip_reg <= ovf;
                if (ovf)
                    res_reg <= sum[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                            : {1'b0, {(ELEM_W-1){1'b1}}};
                else
                    res_reg <= sum[ELEM_W-1:0];
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign clip      = clip_reg;

endmodule

FILE: hdl/mat4a_merge.sv
module mat4a_merge
    import mat4a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             valid,
    input  row_t             row,
    input  logic [LANES-1:0] clip,
    output mat_t             c_rows,
    output logic             full,
    output logic             clip_any
);

    logic [2:0] cnt_reg;
    logic clip_reg;
    mat_t c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (clear)
        begin
            cnt_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (valid)
        begin
            cnt_reg  <= cnt_reg + 3'd1;
            clip_reg <= clip_reg | (|clip);
        end
    end

    // rows arrive in order 0..3; shift in at the top
    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            for (int i = 0; i < ROWS - 1; i++)
                c_reg[i] <= c_reg[i+1];
            c_reg[ROWS-1] <= row;
        end
    end

    assign c_rows   = c_reg;
    assign full     = cnt_reg[2];
    assign clip_any = clip_reg;

endmodule

FILE: hdl/mat4a_store.sv
module mat4a_store
    import mat4a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_ctl_t ctl,
    input  row_t       load_row,
    input  mat_t       c_rows,
    output mat_t       a_rows,
    output mat_t       b_rows
);

    mat_t a_reg;
    mat_t b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            if (ctl.wr_a)
                a_reg <= c_rows;
            else if (ctl.load_a)
                a_reg[ctl.row] <= load_row;
            else if (ctl.rot_a)
                for (int i = 0; i < ROWS; i++)
                    a_reg[i] <= a_reg[(i + 1) % ROWS];

            if (ctl.load_b)
                b_reg[ctl.row] <= load_row;
            else if (ctl.rot_b)
                for (int i = 0; i < ROWS; i++)
                    b_reg[i] <= b_reg[(i + 1) % ROWS];
        end
    end

    assign a_rows = a_reg;
    assign b_rows = b_reg;

endmodule

FILE: hdl/matrix4_accumulate_unit.sv
// 4x4 fixed-point matrix accumulator. Holds A and B in signed Q(32-FRAC_BITS).FRAC_BITS and
// returns row row_index of A after every transaction, with a flag that some element clipped.
// Four column lanes, each with one 32x32 multiplier, process one row of A per cycle in scalar
// and element-wise ops while the rows of A and B rotate past them. Loads, read and unused
// opcodes skip the lanes; scalar and element-wise B ops issue 4 rows; the matrix product
// issues 16 multiply-accumulate steps per lane. One transaction is in work at a time; a
// finished result waits in the output register while the next transaction is accepted.
module matrix4_accumulate_unit
    import mat4a_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [3:0] cnt_reg;
    logic [3:0] op_reg;
    logic [1:0] row_reg;
    elem_t scalar_reg;
    logic arith_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic accept;
    logic is_mulb;
    logic is_scalar;
    logic last_issue;
    logic fin_go;
    logic [1:0] k;
    logic [1:0] mode;

    store_ctl_t st_ctl;
    lane_ctl_t ln_ctl;
    row_t load_row;
    mat_t a_rows;
    mat_t b_rows;
    mat_t c_rows;
    row_t a_head;
    row_t b_head;
    row_t lane_a;
    row_t lane_b;
    row_t lane_res;
    row_t out_row;
    logic [LANES-1:0] lane_valid;
    logic [LANES-1:0] lane_clip;
    logic merge_full;
    logic merge_clip;

    assign accept    = cmd_valid & ~cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign is_mulb   = (op_reg == OP_MULB);
    assign is_scalar = (op_reg == OP_ADDS) || (op_reg == OP_SUBS) || (op_reg == OP_MULS);
    assign k         = cnt_reg[1:0];
    assign last_issue = is_mulb ? (cnt_reg == 4'd15) : (cnt_reg == 4'd3);
    assign fin_go    = (state_reg == ST_FIN) && !(rsp_valid_reg && rsp_stall);
    assign a_head    = a_rows[0];
    assign b_head    = b_rows[0];
    assign load_row  = {cmd.lane3_value, cmd.lane2_value, cmd.lane1_value, cmd.lane0_value};

    always_comb
    begin
        unique case (op_reg) inside
            OP_MULS, OP_MULB: mode = LANE_MUL;
            OP_SUBS, OP_SUBB: mode = LANE_SUB;
            default:          mode = LANE_ADD;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode inside {[OP_ADDS:OP_MULB]})
                        state_next = ST_RUN;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_RUN:
            begin
                if (last_issue)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (merge_full)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                cnt_reg <= '0;
            else if (state_reg == ST_RUN)
                cnt_reg <= cnt_reg + 4'd1;
            if (fin_go)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cmd.opcode;
            row_reg    <= cmd.row_index;
            scalar_reg <= cmd.lane0_value;
            arith_reg  <= (cmd.opcode inside {[OP_ADDS:OP_MULB]});
        end
        if (fin_go)
        begin
            rsp_reg.row_out0  <= out_row[0];
            rsp_reg.row_out1  <= out_row[1];
            rsp_reg.row_out2  <= out_row[2];
            rsp_reg.row_out3  <= out_row[3];
            rsp_reg.saturated <= arith_reg & merge_clip;
        end
    end

    assign out_row = arith_reg ? c_rows[row_reg] : a_rows[row_reg];

    always_comb
    begin
        st_ctl.load_a = accept && (cmd.opcode == OP_LOADA);
        st_ctl.load_b = accept && (cmd.opcode == OP_LOADB);
        st_ctl.row    = cmd.row_index;
        st_ctl.rot_b  = (state_reg == ST_RUN);
        st_ctl.rot_a  = (state_reg == ST_RUN) && (!is_mulb || (k == 2'd3));
        st_ctl.wr_a   = fin_go && arith_reg;
    end

    always_comb
    begin
        ln_ctl.valid = (state_reg == ST_RUN);
        ln_ctl.mode  = mode;
        ln_ctl.first = !is_mulb || (k == 2'd0);
        ln_ctl.last  = !is_mulb || (k == 2'd3);
        for (int j = 0; j < LANES; j++)
        begin
            lane_a[j] = is_mulb ? a_head[k] : a_head[j];
            lane_b[j] = is_scalar ? scalar_reg : b_head[j];
        end
    end

    mat4a_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (st_ctl),
        .load_row (load_row),
        .c_rows   (c_rows),
        .a_rows   (a_rows),
        .b_rows   (b_rows)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        mat4a_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ln_ctl),
            .a         (lane_a[g]),
            .b         (lane_b[g]),
            .res_valid (lane_valid[g]),
            .res       (lane_res[g]),
            .clip      (lane_clip[g])
        );
    end

    mat4a_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .valid    (&lane_valid),
        .row      (lane_res),
        .clip     (lane_clip),
        .c_rows   (c_rows),
        .full     (merge_full),
        .clip_any (merge_clip)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: bench/matrix4_accumulate_unit_test.sv
`timescale 1ns / 100ps

module matrix4_accumulate_unit_test
    import mat4a_pkg::*;
();

    localparam int FRAC_BITS    = 16;
    localparam int RAND_ITEMS   = 1825;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_MAX     = 12;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [3:0] OP_SPARE_LO = 4'd9;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    localparam elem_t Q_MAX  = 32'sh7fff_ffff;
    localparam elem_t Q_MIN  = 32'sh8000_0000;
    localparam elem_t Q_ONE  = 32'sh0001_0000;
    localparam elem_t Q_TWO  = 32'sh0002_0000;
    localparam elem_t Q_HALF = 32'sh0000_8000;

    localparam logic signed [65:0] WIDE_MAX   = 66'sd2147483647;
    localparam logic signed [65:0] WIDE_MIN   = -66'sd2147483648;
    localparam logic signed [65:0] ROUND_BIAS = 66'sd1 <<< (FRAC_BITS - 1);

    typedef struct {
        cmd_t c;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    elem_t    acc_mat [16];
    elem_t    opd_mat [16];
    rsp_t     expected_rows [$];
    dir_row_t dir_tab [$];
    int       errors   = 0;
    int       cycles   = 0;
    int       hold_len = 0;
    bit       no_idle  = 1'b0;

    matrix4_accumulate_unit #(.FRAC_BITS(FRAC_BITS)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_draw();
        if (no_idle)
            return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic elem_t clip_elem(input logic signed [65:0] v, inout logic hit);
        if (v > WIDE_MAX)
        begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (v < WIDE_MIN)
        begin
            hit = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // exact product, rounded half up to FRAC_BITS
    function automatic logic signed [65:0] round_prod(input elem_t a, input elem_t b);
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        wa = a;
        wb = b;
        return (wa * wb + ROUND_BIAS) >>> FRAC_BITS;
    endfunction

    function automatic rsp_t apply_cmd(input cmd_t c);
        elem_t              prod [16];
        elem_t              lane [4];
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        logic signed [65:0] acc_sum;
        logic               hit;
        int                 base;
        int                 i;
        int                 j;
        int                 k;
        rsp_t               r;
        hit = 1'b0;
        base = 4 * int'(c.row_index);
        lane[0] = c.lane0_value;
        lane[1] = c.lane1_value;
        lane[2] = c.lane2_value;
        lane[3] = c.lane3_value;
        wb = lane[0];
        case (c.opcode)
            OP_LOADA:
                for (j = 0; j < 4; j++)
                    acc_mat[base + j] = lane[j];
            OP_LOADB:
                for (j = 0; j < 4; j++)
                    opd_mat[base + j] = lane[j];
            OP_ADDS:
                for (i = 0; i < 16; i++)
                begin
                    wa = acc_mat[i];
                    acc_mat[i] = clip_elem(wa + wb, hit);
                end
            OP_SUBS:
                for (i = 0; i < 16; i++)
                begin
                    wa = acc_mat[i];
                    acc_mat[i] = clip_elem(wa - wb, hit);
                end
            OP_MULS:
                for (i = 0; i < 16; i++)
                    acc_mat[i] = clip_elem(round_prod(acc_mat[i], lane[0]), hit);
            OP_ADDB:
                for (i = 0; i < 16; i++)
                begin
                    wa = acc_mat[i];
                    wb = opd_mat[i];
                    acc_mat[i] = clip_elem(wa + wb, hit);
                end
            OP_SUBB:
                for (i = 0; i < 16; i++)
                begin
                    wa = acc_mat[i];
                    wb = opd_mat[i];
                    acc_mat[i] = clip_elem(wa - wb, hit);
                end
            OP_MULB:
            begin
                for (i = 0; i < 4; i++)
                    for (j = 0; j < 4; j++)
                    begin
                        acc_sum = '0;
                        for (k = 0; k < 4; k++)
                            acc_sum = acc_sum + round_prod(acc_mat[i * 4 + k], opd_mat[k * 4 + j]);
                        prod[i * 4 + j] = clip_elem(acc_sum, hit);
                    end
                for (i = 0; i < 16; i++)
                    acc_mat[i] = prod[i];
            end
            default:
                ;
        endcase
        r.row_out0  = acc_mat[base];
        r.row_out1  = acc_mat[base + 1];
        r.row_out2  = acc_mat[base + 2];
        r.row_out3  = acc_mat[base + 3];
        r.saturated = hit;
        return r;
    endfunction

    function automatic elem_t rand_elem();
        elem_t v;
        case ($urandom_range(0, 9)) inside
            0:
                case ($urandom_range(0, 4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = 1;
                    default: v = -1;
                endcase
            1, 2:
                v = $urandom;
            default:
            begin
                v = $urandom_range(0, 32'h0004_0000);
                v = v - Q_TWO;
            end
        endcase
        return v;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t  c;
        elem_t v;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            c.opcode = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (pick < 30)
            c.opcode = OP_LOADA;
        else if (pick < 45)
            c.opcode = OP_LOADB;
        else
            c.opcode = 4'($urandom_range(OP_ADDS, OP_READ));
        c.row_index   = 2'($urandom_range(0, ROWS - 1));
        c.lane0_value = rand_elem();
        c.lane1_value = rand_elem();
        c.lane2_value = rand_elem();
        c.lane3_value = rand_elem();
        // keep most scalar multiplies near unity so A does not collapse or blow up
        if (c.opcode == OP_MULS && $urandom_range(0, 3) != 0)
        begin
            v = $urandom_range(0, 32'h0000_4000);
            c.lane0_value = Q_ONE + v - 32'sh0000_2000;
        end
        return c;
    endfunction

    task automatic add_cmd(input logic [3:0] op, input logic [1:0] r,
                           input elem_t l0, input elem_t l1, input elem_t l2, input elem_t l3);
        dir_row_t d;
        d.c.opcode      = op;
        d.c.row_index   = r;
        d.c.lane0_value = l0;
        d.c.lane1_value = l1;
        d.c.lane2_value = l2;
        d.c.lane3_value = l3;
        d.typed         = 1'b0;
        d.want          = '0;
        dir_tab.push_back(d);
    endtask

    task automatic typed_want(input elem_t w0, input elem_t w1, input elem_t w2,
                              input elem_t w3, input logic ws);
        rsp_t r;
        r.row_out0  = w0;
        r.row_out1  = w1;
        r.row_out2  = w2;
        r.row_out3  = w3;
        r.saturated = ws;
        dir_tab[dir_tab.size() - 1].typed = 1'b1;
        dir_tab[dir_tab.size() - 1].want  = r;
    endtask

    task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t want);
        int   gap;
        rsp_t pred;
        gap = idle_draw();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pred = apply_cmd(c);
        expected_rows.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rows.size() == 0)
            begin
                errors++;
                $display("%0t unexpected transaction, expected none got %h", $time, rsp);
            end
            else
            begin
                w = expected_rows.pop_front();
                check_field("row_out0", w.row_out0, rsp.row_out0);
                check_field("row_out1", w.row_out1, rsp.row_out1);
                check_field("row_out2", w.row_out2, rsp.row_out2);
                check_field("row_out3", w.row_out3, rsp.row_out3);
                check_field("saturated", 32'(w.saturated), 32'(rsp.saturated));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[matrix4_accumulate_unit] ERROR");
            $finish;
        end
    end

    initial
    begin : rsp_side
        int n;
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
            end
            else
                n = idle_draw();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int sent;
        for (int i = 0; i < 16; i++)
        begin
            acc_mat[i] = '0;
            opd_mat[i] = '0;
        end

        add_cmd(OP_READ, 0, 0, 0, 0, 0);
        typed_want(0, 0, 0, 0, 1'b0);
        add_cmd(OP_LOADA, 0, Q_MAX, Q_MIN, 1, -1);
        typed_want(Q_MAX, Q_MIN, 1, -1, 1'b0);
        add_cmd(OP_LOADA, 3, Q_ONE, -Q_ONE, Q_HALF, -Q_HALF);
        typed_want(Q_ONE, -Q_ONE, Q_HALF, -Q_HALF, 1'b0);
        add_cmd(OP_LOADB, 1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        typed_want(0, 0, 0, 0, 1'b0);
        add_cmd(OP_LOADB, 0, Q_ONE, 0, 0, 0);
        add_cmd(OP_LOADB, 2, 0, 0, Q_ONE, 0);
        add_cmd(OP_LOADB, 3, Q_MIN, 0, 0, Q_MAX);
        // +1 everywhere: the max element clips
        add_cmd(OP_ADDS, 0, 1, 0, 0, 0);
        typed_want(Q_MAX, 32'sh8000_0001, 2, 0, 1'b1);
        // scalar is the most negative value; other lanes are junk
        add_cmd(OP_SUBS, 1, Q_MIN, Q_MAX, Q_MIN, 32'sh5a5a_5a5a);
        add_cmd(OP_LOADA, 1, Q_TWO, -Q_ONE, 1, -1);
        // half-LSB products round toward plus infinity
        add_cmd(OP_MULS, 1, Q_HALF, -1, -1, -1);
        add_cmd(OP_MULS, 0, -Q_ONE, 0, 0, 0);
        add_cmd(OP_MULS, 3, Q_MIN, 0, 0, 0);
        add_cmd(OP_ADDB, 2, 0, 0, 0, 0);
        add_cmd(OP_SUBB, 1, 0, 0, 0, 0);
        add_cmd(OP_LOADA, 0, Q_ONE, Q_HALF, 0, -Q_ONE);
        add_cmd(OP_LOADA, 3, -Q_HALF, Q_TWO, 3, -7);
        add_cmd(OP_MULB, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_cmd(OP_LOADA, 2, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_cmd(OP_LOADB, 2, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_cmd(OP_MULB, 2, 0, 0, 0, 0);
        add_cmd(OP_SPARE_LO, 1, Q_MAX, Q_MIN, 1, 1);
        add_cmd(OP_SPARE_HI, 3, Q_MIN, Q_MAX, -1, -1);
        add_cmd(OP_READ, 2, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_cmd(OP_LOADA, 2, 0, 0, 0, 0);
        typed_want(0, 0, 0, 0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want);
        wait_drained();

        for (sent = 0; sent < RAND_ITEMS; sent++)
        begin
            if (sent % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // receiver holds off while the sender keeps pushing back to back
            if (sent == 500)
            begin
                hold_len = LONG_HOLD;
                no_idle  = 1'b1;
            end
            if (sent == 1000 || sent == 1400)
                wait_drained();
            send_cmd(rand_cmd(), 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[matrix4_accumulate_unit] OK");
        else
            $display("[matrix4_accumulate_unit] ERROR");
        $finish;
    end

endmodule
